/* sv/gps_week_to_calendar_date_assert.svh */
// Assertion macros for the GPS week to calendar date converter.
`ifndef GPS_WEEK_TO_CALENDAR_DATE_ASSERT_SVH
`define GPS_WEEK_TO_CALENDAR_DATE_ASSERT_SVH

// Check a condition in the same cycle as the trigger.
`define GWC_ASSERT_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// Check a condition in the cycle after the trigger.
`define GWC_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

/* sv/gwcal_pkg.sv */
// Constants and month table for the GPS week to calendar date converter.
package gwcal_pkg;

  localparam int WEEK_BITS_DEFAULT = 13;
  localparam int TOW_W             = 30;
  localparam int YEAR_W            = 12;

  localparam logic [TOW_W-1:0]  MS_PER_MINUTE    = 30'd60000;
  localparam logic [TOW_W-1:0]  MS_PER_HOUR      = 30'd3600000;
  localparam logic [TOW_W-1:0]  MS_PER_DAY       = 30'd86400000;
  localparam logic [TOW_W-1:0]  MS_PER_WEEK      = 30'd604800000;
  localparam logic [YEAR_W-1:0] EPOCH_YEAR       = 12'd1980;
  localparam logic [2:0]        EPOCH_DAY_OFFSET = 3'd5;

  // 1980 modulo 4, 100 and 400
  localparam logic [1:0] EPOCH_MOD4   = 2'd0;
  localparam logic [6:0] EPOCH_MOD100 = 7'd80;
  localparam logic [8:0] EPOCH_MOD400 = 9'd380;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
    logic [4:0] len;
    case (mon)
      MONTH_FEB: len = 5'd28 + {4'd0, leap};
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* sv/gps_week_to_calendar_date.sv */
// GPS week and time of week to Gregorian calendar date, one shared subtractor.
//
//  channel  | ports                                      | handshake
//  ---------+--------------------------------------------+------------------------
//  request  | gps_week, time_of_week_ms                  | start && !busy
//  result   | year, month, day_of_month, hour, minute,   | done, one cycle strobe
//           | ms_of_minute, range_error                  |
//
// A transaction first checks the time of week and ends with range_error when it is out
// of range; otherwise a single subtract-and-compare unit walks days, hours, minutes,
// years and months, taking off one day, hour, minute, year or month per step.
// busy rises at the accepting edge and falls as done rises; start is ignored meanwhile.
// Synchronous reset clears the sequencer; results cannot be stalled.
`include "gps_week_to_calendar_date_assert.svh"

module gps_week_to_calendar_date
  import gwcal_pkg::*;
#(
  parameter int WEEK_BITS = WEEK_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [WEEK_BITS-1:0] gps_week,
  input  logic [TOW_W-1:0]     time_of_week_ms,
  output logic                 done,
  output logic [YEAR_W-1:0]    year,
  output logic [3:0]           month,
  output logic [4:0]           day_of_month,
  output logic [4:0]           hour,
  output logic [5:0]           minute,
  output logic [15:0]          ms_of_minute,
  output logic                 range_error
);

  localparam int DAYS_W = WEEK_BITS + 3;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_DAY, S_HOUR, S_MIN, S_YEAR, S_MONTH
  } state_t;

  state_t               state;
  logic [WEEK_BITS-1:0] week_r;
  logic [TOW_W-1:0]     ms;
  logic [DAYS_W-1:0]    days;
  logic [2:0]           dow;
  logic [4:0]           hr_cnt;
  logic [5:0]           min_cnt;
  logic [YEAR_W-1:0]    yr_cnt;
  logic [3:0]           mon_cnt;
  logic [1:0]           mod4;
  logic [6:0]           mod100;
  logic [8:0]           mod400;

  logic                 leap;
  logic [TOW_W-1:0]     op_a;
  logic [TOW_W-1:0]     op_b;
  logic [TOW_W:0]       sub;
  logic                 geq;
  logic [DAYS_W-1:0]    days_load;

  assign leap = ((mod4 == 2'd0) && (mod100 != 7'd0)) || (mod400 == 9'd0);

  // shared subtract-and-compare unit
  always_comb begin
    op_a = ms;
    op_b = MS_PER_WEEK;
    case (state)
      S_CHECK: op_b = MS_PER_WEEK;
      S_DAY:   op_b = MS_PER_DAY;
      S_HOUR:  op_b = MS_PER_HOUR;
      S_MIN:   op_b = MS_PER_MINUTE;
      S_YEAR: begin
        op_a = TOW_W'(days);
        op_b = TOW_W'(10'd365 + {9'd0, leap});
      end
      S_MONTH: begin
        op_a = TOW_W'(days);
        op_b = TOW_W'(month_len(leap, mon_cnt));
      end
      default: op_b = MS_PER_WEEK;
    endcase
    sub = {1'b0, op_a} - {1'b0, op_b};
    geq = ~sub[TOW_W];
  end

  // week * 7 + day of week + epoch offset
  assign days_load = {week_r, 3'b000} - DAYS_W'(week_r) + DAYS_W'(dow)
                   + DAYS_W'(EPOCH_DAY_OFFSET);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            week_r  <= gps_week;
            ms      <= time_of_week_ms;
            dow     <= 3'd0;
            hr_cnt  <= 5'd0;
            min_cnt <= 6'd0;
            yr_cnt  <= EPOCH_YEAR;
            mod4    <= EPOCH_MOD4;
            mod100  <= EPOCH_MOD100;
            mod400  <= EPOCH_MOD400;
            mon_cnt <= MONTH_JAN;
            busy    <= 1'b1;
            state   <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (geq) begin
            year         <= '0;
            month        <= '0;
            day_of_month <= '0;
            hour         <= '0;
            minute       <= '0;
            ms_of_minute <= '0;
            range_error  <= 1'b1;
            done         <= 1'b1;
            busy         <= 1'b0;
            state        <= S_IDLE;
          end else begin
            state <= S_DAY;
          end
        end
        S_DAY: begin
          if (geq) begin
            ms  <= sub[TOW_W-1:0];
            dow <= dow + 3'd1;
          end else begin
            days  <= days_load;
            state <= S_HOUR;
          end
        end
        S_HOUR: begin
          if (geq) begin
            ms     <= sub[TOW_W-1:0];
            hr_cnt <= hr_cnt + 5'd1;
          end else begin
            state <= S_MIN;
          end
        end
        S_MIN: begin
          if (geq) begin
            ms      <= sub[TOW_W-1:0];
            min_cnt <= min_cnt + 6'd1;
          end else begin
            state <= S_YEAR;
          end
        end
        S_YEAR: begin
          // advance one year and its residues per cycle
          if (geq) begin
            days   <= sub[DAYS_W-1:0];
            yr_cnt <= yr_cnt + 12'd1;
            mod4   <= mod4 + 2'd1;
            mod100 <= (mod100 == 7'd99) ? 7'd0 : mod100 + 7'd1;
            mod400 <= (mod400 == 9'd399) ? 9'd0 : mod400 + 9'd1;
          end else begin
            state <= S_MONTH;
          end
        end
        S_MONTH: begin
          if (geq && (mon_cnt < MONTH_DEC)) begin
            days    <= sub[DAYS_W-1:0];
            mon_cnt <= mon_cnt + 4'd1;
          end else begin
            year         <= yr_cnt;
            month        <= mon_cnt;
            day_of_month <= days[4:0] + 5'd1;
            hour         <= hr_cnt;
            minute       <= min_cnt;
            ms_of_minute <= ms[15:0];
            range_error  <= 1'b0;
            done         <= 1'b1;
            busy         <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: begin
          done  <= 1'b0;
          busy  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  `GWC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
  `GWC_ASSERT_NEXT(a_done_pulse, done, !done, "done held longer than one cycle")
  `GWC_ASSERT_NOW(a_done_idle, done, !busy && (state == S_IDLE), "done while still working")
  `GWC_ASSERT_NOW(a_err_zero, done && range_error, (year == '0) && (month == '0) && (ms_of_minute == '0), "range error with nonzero fields")
  `GWC_ASSERT_NOW(a_fields_ok, done && !range_error, (month >= MONTH_JAN) && (month <= MONTH_DEC) && (day_of_month != 5'd0) && (hour <= 5'd23) && (minute <= 6'd59) && (ms_of_minute <= 16'd59999), "date or time field out of range")

endmodule
